// ----- src/sae_pkg.sv -----
// Shared types and constants for the suffix automaton engine.
// No dependencies; every other file refers to it by scoped names.
package sae_pkg;

  localparam int MAX_TEXT_LEN_DEF  = 512;
  localparam int ALPHABET_SIZE_DEF = 26;

  // Result status codes
  localparam logic [1:0] ST_ANSWER = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  // Input action codes
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    CMD_IDLE, CMD_TAKE, CMD_RST_ROOT, CMD_CLR, CMD_NEW, CMD_RD_CUR, CMD_LINK,
    CMD_RD_T, CMD_SOLID, CMD_CLONE, CMD_CLONE_T, CMD_CLONE_B, CMD_COPY,
    CMD_COPY_TAIL, CMD_REDIR, CMD_FINISH, CMD_MARK, CMD_CLOSE, CMD_Q_START,
    CMD_Q_STEP, CMD_Q_RD, CMD_Q_ANS, CMD_EMIT_ANS, CMD_EMIT_FULL, CMD_EMIT_CLOSED
  } cmd_t;

  // Controller states
  typedef enum logic [4:0] {
    S_RST_ROOT, S_CLR_ROOT, S_IDLE, S_DECODE, S_CLR_ROW, S_WALK_RD, S_WALK_EV,
    S_T_EV, S_CLONE_T, S_CLONE_B, S_COPY, S_COPY_TAIL, S_RED_RD, S_RED_EV,
    S_FINISH, S_MARK_RD, S_MARK_WR, S_Q_STEP, S_Q_RD, S_Q_ANS, S_EMIT_ANS,
    S_EMIT_FULL, S_EMIT_CLOSED
  } state_t;

  // Status from datapath to controller
  typedef struct packed {
    logic act;
    logic last;
    logic closed;
    logic full;
    logic bad_sym;
    logic cur_none;
    logic rd_none;
    logic rd_is_t;
    logic solid;
    logic col_last;
    logic out_free;
  } stat_t;

endpackage

// ----- src/sae_datapath.sv -----
// Datapath: transition and per-state memories, walk registers, result word.
// Depends on sae_pkg; driven one command per cycle by sae_ctrl.
module sae_datapath #(
  parameter int MAX_TEXT_LEN  = sae_pkg::MAX_TEXT_LEN_DEF,
  parameter int ALPHABET_SIZE = sae_pkg::ALPHABET_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            action,
  input  logic [4:0]      symbol,
  input  logic            first,
  input  logic            last,
  input  sae_pkg::cmd_t   cmd,
  output sae_pkg::stat_t  stat,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic            found
);

  localparam int DEPTH  = 2 * MAX_TEXT_LEN + 1;
  localparam int SW     = $clog2(DEPTH + 1);
  localparam int CW     = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int LW     = $clog2(MAX_TEXT_LEN + 1);
  localparam int TDEPTH = DEPTH << CW;
  localparam int SMW    = 2 * SW + 1;
  localparam logic [SW-1:0] NONE = {SW{1'b1}};

  // Memories: transitions by {state, letter}; per state {link, parent, terminal}
  logic [SW-1:0]  tmem [TDEPTH];
  logic [SMW-1:0] smem [DEPTH];
  logic [SW-1:0]  trans_rd;
  logic [SMW-1:0] smem_rd;

  logic              tr_re, tr_we, sm_re, sm_we;
  logic [SW+CW-1:0]  tr_ra, tr_wa;
  logic [SW-1:0]     tr_wd, sm_ra, sm_wa;
  logic [SMW-1:0]    sm_wd;

  // Item and walk registers
  logic          it_act, it_first, it_last;
  logic [4:0]    it_sym;
  logic [SW-1:0] cur, b, bpar, t, d, tpar, next_free, last_st, qcur;
  logic          tflag, qdead, closed, copy_pend, ans;
  logic [LW-1:0] len;
  logic [CW-1:0] col, col_q;

  logic [CW-1:0] it_col;
  logic          bad_sym;
  logic [SW-1:0] rd_link, rd_par;
  logic          rd_flag;
  logic [SW-1:0] q_cur_n;
  logic          q_dead_n;
  logic          emit;

  assign it_col  = CW'({{CW{1'b0}}, it_sym});
  assign bad_sym = int'(it_sym) >= ALPHABET_SIZE;
  assign rd_link = smem_rd[SMW-1 -: SW];
  assign rd_par  = smem_rd[SW:1];
  assign rd_flag = smem_rd[0];
  assign q_cur_n  = it_first ? '0 : qcur;
  assign q_dead_n = (it_first ? 1'b0 : qdead) | bad_sym;
  assign emit = cmd == sae_pkg::CMD_EMIT_ANS || cmd == sae_pkg::CMD_EMIT_FULL ||
                cmd == sae_pkg::CMD_EMIT_CLOSED;

  // Status to controller
  always_comb begin
    stat.act      = it_act;
    stat.last     = it_last;
    stat.closed   = closed;
    stat.full     = len >= LW'(MAX_TEXT_LEN);
    stat.bad_sym  = bad_sym;
    stat.cur_none = cur == NONE;
    stat.rd_none  = trans_rd == NONE;
    stat.rd_is_t  = trans_rd == t;
    stat.solid    = rd_par == cur;
    stat.col_last = col == CW'(ALPHABET_SIZE - 1);
    stat.out_free = !out_valid || !out_stall;
  end

  // Decode command into memory ports
  always_comb begin
    tr_re = 1'b0; tr_ra = '0; tr_we = 1'b0; tr_wa = '0; tr_wd = '0;
    sm_re = 1'b0; sm_ra = '0; sm_we = 1'b0; sm_wa = '0; sm_wd = '0;
    unique case (cmd)
      sae_pkg::CMD_RST_ROOT: begin
        sm_we = 1'b1; sm_wa = '0; sm_wd = {NONE, NONE, 1'b0};
      end
      sae_pkg::CMD_CLR: begin
        tr_we = 1'b1; tr_wa = {b, col}; tr_wd = NONE;
      end
      sae_pkg::CMD_NEW: begin
        sm_we = 1'b1; sm_wa = next_free; sm_wd = {SW'(0), last_st, 1'b0};
      end
      sae_pkg::CMD_RD_CUR: begin
        tr_re = 1'b1; tr_ra = {cur, it_col};
        sm_re = 1'b1; sm_ra = cur;
      end
      sae_pkg::CMD_LINK: begin
        tr_we = 1'b1; tr_wa = {cur, it_col}; tr_wd = b;
      end
      sae_pkg::CMD_RD_T: begin
        sm_re = 1'b1; sm_ra = trans_rd;
      end
      sae_pkg::CMD_SOLID: begin
        sm_we = 1'b1; sm_wa = b; sm_wd = {t, bpar, 1'b0};
      end
      sae_pkg::CMD_CLONE: begin
        sm_we = 1'b1; sm_wa = next_free; sm_wd = {rd_link, cur, 1'b0};
      end
      sae_pkg::CMD_CLONE_T: begin
        sm_we = 1'b1; sm_wa = t; sm_wd = {d, tpar, tflag};
      end
      sae_pkg::CMD_CLONE_B: begin
        sm_we = 1'b1; sm_wa = b; sm_wd = {d, bpar, 1'b0};
      end
      sae_pkg::CMD_COPY: begin
        tr_re = 1'b1; tr_ra = {t, col};
        tr_we = copy_pend; tr_wa = {d, col_q}; tr_wd = trans_rd;
      end
      sae_pkg::CMD_COPY_TAIL: begin
        tr_we = 1'b1; tr_wa = {d, col_q}; tr_wd = trans_rd;
      end
      sae_pkg::CMD_REDIR: begin
        tr_we = 1'b1; tr_wa = {cur, it_col}; tr_wd = d;
      end
      sae_pkg::CMD_MARK: begin
        sm_we = 1'b1; sm_wa = cur; sm_wd = {rd_link, rd_par, 1'b1};
      end
      sae_pkg::CMD_Q_START: begin
        tr_re = 1'b1; tr_ra = {q_cur_n, it_col};
      end
      sae_pkg::CMD_Q_RD: begin
        sm_re = 1'b1; sm_ra = qcur;
      end
      default: begin
      end
    endcase
  end

  // Memory ports with registered read data
  always_ff @(posedge clk) begin
    if (tr_we) tmem[tr_wa] <= tr_wd;
    if (tr_re) trans_rd <= tmem[tr_ra];
    if (sm_we) smem[sm_wa] <= sm_wd;
    if (sm_re) smem_rd <= smem[sm_ra];
  end

  // Walk, query and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      closed    <= 1'b0;
      len       <= '0;
      next_free <= SW'(1);
      last_st   <= '0;
      qcur      <= '0;
      qdead     <= 1'b0;
      b         <= '0;
      col       <= '0;
      copy_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Load a new result word or drop the one taken
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (cmd)
        sae_pkg::CMD_TAKE: begin
          it_act <= action; it_sym <= symbol; it_first <= first; it_last <= last;
        end
        sae_pkg::CMD_CLR: col <= col + CW'(1);
        sae_pkg::CMD_NEW: begin
          b <= next_free; bpar <= last_st; cur <= last_st;
          next_free <= next_free + SW'(1); col <= '0;
        end
        sae_pkg::CMD_LINK:  cur <= rd_link;
        sae_pkg::CMD_RD_T:  t <= trans_rd;
        sae_pkg::CMD_CLONE: begin
          d <= next_free; next_free <= next_free + SW'(1);
          tpar <= rd_par; tflag <= rd_flag; col <= '0; copy_pend <= 1'b0;
        end
        sae_pkg::CMD_COPY: begin
          col_q <= col; col <= col + CW'(1); copy_pend <= 1'b1;
        end
        sae_pkg::CMD_REDIR:  cur <= rd_link;
        sae_pkg::CMD_FINISH: begin
          last_st <= b; len <= len + LW'(1); cur <= b;
        end
        sae_pkg::CMD_MARK:    cur <= rd_link;
        sae_pkg::CMD_CLOSE:   closed <= 1'b1;
        sae_pkg::CMD_Q_START: begin
          qcur <= q_cur_n; qdead <= q_dead_n;
        end
        sae_pkg::CMD_Q_STEP: begin
          if (!qdead) begin
            if (trans_rd == NONE) qdead <= 1'b1;
            else qcur <= trans_rd;
          end
        end
        sae_pkg::CMD_Q_ANS: ans <= !qdead && rd_flag;
        sae_pkg::CMD_EMIT_ANS: begin
          status <= sae_pkg::ST_ANSWER; found <= ans;
        end
        sae_pkg::CMD_EMIT_FULL: begin
          status <= sae_pkg::ST_FULL; found <= 1'b0;
        end
        sae_pkg::CMD_EMIT_CLOSED: begin
          status <= sae_pkg::ST_CLOSED; found <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/sae_ctrl.sv -----
// Controller: sequences appends, clones, terminal marking and queries.
// Depends on sae_pkg; drives sae_datapath through cmd and reads stat.
module sae_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sae_pkg::stat_t  stat,
  output sae_pkg::cmd_t   cmd
);

  sae_pkg::state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= sae_pkg::S_RST_ROOT;
    else state <= state_next;
  end

  assign in_stall = state != sae_pkg::S_IDLE;

  // Next state and command
  always_comb begin
    state_next = state;
    cmd        = sae_pkg::CMD_IDLE;
    unique case (state)
      sae_pkg::S_RST_ROOT: begin
        cmd = sae_pkg::CMD_RST_ROOT; state_next = sae_pkg::S_CLR_ROOT;
      end
      sae_pkg::S_CLR_ROOT: begin
        cmd = sae_pkg::CMD_CLR;
        if (stat.col_last) state_next = sae_pkg::S_IDLE;
      end
      sae_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd = sae_pkg::CMD_TAKE; state_next = sae_pkg::S_DECODE;
        end
      end
      sae_pkg::S_DECODE: begin
        priority if (stat.act == sae_pkg::ACT_QUERY) begin
          cmd = sae_pkg::CMD_Q_START; state_next = sae_pkg::S_Q_STEP;
        end else if (stat.closed) begin
          state_next = sae_pkg::S_EMIT_CLOSED;
        end else if (stat.full) begin
          state_next = sae_pkg::S_EMIT_FULL;
        end else if (stat.bad_sym) begin
          state_next = sae_pkg::S_IDLE;
        end else begin
          cmd = sae_pkg::CMD_NEW; state_next = sae_pkg::S_CLR_ROW;
        end
      end
      sae_pkg::S_CLR_ROW: begin
        cmd = sae_pkg::CMD_CLR;
        if (stat.col_last) state_next = sae_pkg::S_WALK_RD;
      end
      sae_pkg::S_WALK_RD: begin
        if (stat.cur_none) state_next = sae_pkg::S_FINISH;
        else begin
          cmd = sae_pkg::CMD_RD_CUR; state_next = sae_pkg::S_WALK_EV;
        end
      end
      sae_pkg::S_WALK_EV: begin
        if (stat.rd_none) begin
          cmd = sae_pkg::CMD_LINK; state_next = sae_pkg::S_WALK_RD;
        end else begin
          cmd = sae_pkg::CMD_RD_T; state_next = sae_pkg::S_T_EV;
        end
      end
      sae_pkg::S_T_EV: begin
        if (stat.solid) begin
          cmd = sae_pkg::CMD_SOLID; state_next = sae_pkg::S_FINISH;
        end else begin
          cmd = sae_pkg::CMD_CLONE; state_next = sae_pkg::S_CLONE_T;
        end
      end
      sae_pkg::S_CLONE_T: begin
        cmd = sae_pkg::CMD_CLONE_T; state_next = sae_pkg::S_CLONE_B;
      end
      sae_pkg::S_CLONE_B: begin
        cmd = sae_pkg::CMD_CLONE_B; state_next = sae_pkg::S_COPY;
      end
      sae_pkg::S_COPY: begin
        cmd = sae_pkg::CMD_COPY;
        if (stat.col_last) state_next = sae_pkg::S_COPY_TAIL;
      end
      sae_pkg::S_COPY_TAIL: begin
        cmd = sae_pkg::CMD_COPY_TAIL; state_next = sae_pkg::S_RED_RD;
      end
      sae_pkg::S_RED_RD: begin
        if (stat.cur_none) state_next = sae_pkg::S_FINISH;
        else begin
          cmd = sae_pkg::CMD_RD_CUR; state_next = sae_pkg::S_RED_EV;
        end
      end
      sae_pkg::S_RED_EV: begin
        if (stat.rd_is_t) begin
          cmd = sae_pkg::CMD_REDIR; state_next = sae_pkg::S_RED_RD;
        end else state_next = sae_pkg::S_FINISH;
      end
      sae_pkg::S_FINISH: begin
        cmd = sae_pkg::CMD_FINISH;
        state_next = stat.last ? sae_pkg::S_MARK_RD : sae_pkg::S_IDLE;
      end
      sae_pkg::S_MARK_RD: begin
        if (stat.cur_none) begin
          cmd = sae_pkg::CMD_CLOSE; state_next = sae_pkg::S_IDLE;
        end else begin
          cmd = sae_pkg::CMD_RD_CUR; state_next = sae_pkg::S_MARK_WR;
        end
      end
      sae_pkg::S_MARK_WR: begin
        cmd = sae_pkg::CMD_MARK; state_next = sae_pkg::S_MARK_RD;
      end
      sae_pkg::S_Q_STEP: begin
        cmd = sae_pkg::CMD_Q_STEP;
        state_next = stat.last ? sae_pkg::S_Q_RD : sae_pkg::S_IDLE;
      end
      sae_pkg::S_Q_RD: begin
        cmd = sae_pkg::CMD_Q_RD; state_next = sae_pkg::S_Q_ANS;
      end
      sae_pkg::S_Q_ANS: begin
        cmd = sae_pkg::CMD_Q_ANS; state_next = sae_pkg::S_EMIT_ANS;
      end
      sae_pkg::S_EMIT_ANS: begin
        if (stat.out_free) begin
          cmd = sae_pkg::CMD_EMIT_ANS; state_next = sae_pkg::S_IDLE;
        end
      end
      sae_pkg::S_EMIT_FULL: begin
        if (stat.out_free) begin
          cmd = sae_pkg::CMD_EMIT_FULL; state_next = sae_pkg::S_IDLE;
        end
      end
      sae_pkg::S_EMIT_CLOSED: begin
        if (stat.out_free) begin
          cmd = sae_pkg::CMD_EMIT_CLOSED; state_next = sae_pkg::S_IDLE;
        end
      end
      default: state_next = sae_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- src/suffix_automaton_engine.sv -----
// Top level of the suffix automaton engine: controller plus datapath.
// Depends on sae_pkg, sae_ctrl and sae_datapath.
//
//   channel | signals                            | direction
//   in      | in_valid, in_stall, action, symbol, first, last | word into block
//   out     | out_valid, out_stall, status, found              | word out of block
//
// One word at a time. An append clears the transition row of its new state, then
// walks suffix links; a clone copies a transition row and redirects edges, and a
// last append marks the terminal states. A query reads and emits a result on its last symbol.
// The transition memory takes one read and one write per cycle.
// After reset, the root row is cleared before in_stall drops.
// A result waits in the output register while out_stall is high.
module suffix_automaton_engine #(
  parameter int MAX_TEXT_LEN  = sae_pkg::MAX_TEXT_LEN_DEF,
  parameter int ALPHABET_SIZE = sae_pkg::ALPHABET_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [4:0] symbol,
  input  logic       first,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic       found
);

  sae_pkg::cmd_t  cmd;
  sae_pkg::stat_t stat;

  sae_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  sae_datapath #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN), .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_dp (
    .clk(clk), .rst(rst), .action(action), .symbol(symbol), .first(first),
    .last(last), .cmd(cmd), .stat(stat), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .found(found)
  );

endmodule

// ----- src/sae_checker.sv -----
// Port-level checks for the suffix automaton engine, bound to the top level.
// Depends on sae_pkg and suffix_automaton_engine.
module sae_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       action,
  input logic [4:0] symbol,
  input logic       first,
  input logic       last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic       found
);

  // Result word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found))
    else $error("stalled result word changed");

  // Only defined status codes leave the block
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == sae_pkg::ST_ANSWER || status == sae_pkg::ST_FULL ||
                   status == sae_pkg::ST_CLOSED))
    else $error("undefined status code");

  // Rejections never report a match
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sae_pkg::ST_ANSWER |-> !found)
    else $error("found set on a rejection");

  // Reset empties the output and holds off input
  a_rst: assert property (@(posedge clk) rst |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

endmodule

bind suffix_automaton_engine sae_checker u_sae_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for suffix_automaton_engine: builds one text online,
// closes it, and checks suffix queries against a built-in automaton predictor.
// Depends on sae_pkg and the RTL of suffix_automaton_engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_CAP  = sae_pkg::MAX_TEXT_LEN_DEF;
  localparam int ALPHA     = sae_pkg::ALPHABET_SIZE_DEF;
  localparam int DEPTH     = 2 * TEXT_CAP + 1;
  localparam logic [10:0] NO_STATE = 11'h7FF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic       act;
    logic [4:0] sym;
    logic       first;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = sae_pkg::ACT_APPEND;
  logic [4:0] symbol = '0;
  logic first = 1'b0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic found;

  suffix_automaton_engine dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .symbol(symbol), .first(first), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .found(found)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Automaton mirror
  logic [10:0] edges [DEPTH*ALPHA];
  logic [10:0] sfx [DEPTH];
  logic [10:0] solid [DEPTH];
  logic        term [DEPTH];
  int unsigned free_id, tail_id, cursor, text_len;
  logic        dead, closed;

  word_t   pending [$];
  answer_t answers [$];
  int      accepted_words, seen_results, fail_count, hits, n_appends, n_queries, total_words;
  int      quiet_cycles;
  bit      hold_done;

  logic [4:0] text [$];

  function automatic logic [10:0] edge_of(int unsigned st, int unsigned c);
    if (st >= DEPTH || c >= ALPHA) return NO_STATE;
    return edges[st*ALPHA + c];
  endfunction

  function automatic void put_edge(int unsigned st, int unsigned c, logic [10:0] to);
    if (st < DEPTH && c < ALPHA) edges[st*ALPHA + c] = to;
  endfunction

  function automatic void clear_automaton();
    foreach (edges[i]) edges[i] = NO_STATE;
    foreach (sfx[i]) begin
      sfx[i] = NO_STATE;
      solid[i] = NO_STATE;
      term[i] = 1'b0;
    end
    free_id = 1; tail_id = 0; cursor = 0; text_len = 0;
    dead = 1'b0; closed = 1'b0;
  endfunction

  // Extend the automaton by one letter, cloning where an edge is not solid
  function automatic void extend(int unsigned c);
    int unsigned st, nb, t, cl;
    st = tail_id;
    nb = free_id++;
    if (nb >= DEPTH) return;
    sfx[nb] = '0;
    solid[nb] = 11'(st);
    for (int g = 0; st < DEPTH && g < DEPTH; g++) begin
      t = edge_of(st, c);
      if (t == NO_STATE) begin
        put_edge(st, c, 11'(nb));
        st = (st < DEPTH) ? sfx[st] : NO_STATE;
        continue;
      end
      if (t >= DEPTH) break;
      if (solid[t] == st) begin
        sfx[nb] = 11'(t);
        break;
      end
      cl = free_id++;
      if (cl >= DEPTH) break;
      solid[cl] = 11'(st);
      for (int k = 0; k < ALPHA; k++) edges[cl*ALPHA + k] = edges[t*ALPHA + k];
      sfx[cl] = sfx[t];
      sfx[t] = 11'(cl);
      sfx[nb] = 11'(cl);
      for (int h = 0; st < DEPTH && edge_of(st, c) == t && h < DEPTH; h++) begin
        put_edge(st, c, 11'(cl));
        st = sfx[st];
      end
      break;
    end
    tail_id = nb;
  endfunction

  // Predict the response to one accepted word
  function automatic void predict_word(word_t w);
    int unsigned st, nx;
    if (w.act == sae_pkg::ACT_APPEND) begin
      n_appends++;
      if (closed) begin
        answers.push_back('{sae_pkg::ST_CLOSED, 1'b0});
        return;
      end
      if (text_len >= TEXT_CAP) begin
        answers.push_back('{sae_pkg::ST_FULL, 1'b0});
        return;
      end
      if (w.sym >= ALPHA) return;
      extend(w.sym);
      text_len++;
      if (w.last) begin
        st = tail_id;
        for (int g = 0; st < DEPTH && g < DEPTH; g++) begin
          term[st] = 1'b1;
          st = sfx[st];
        end
        closed = 1'b1;
      end
      return;
    end
    n_queries++;
    if (w.first) begin
      cursor = 0;
      dead = 1'b0;
    end
    if (!dead) begin
      nx = edge_of(cursor, w.sym);
      if (nx >= DEPTH) dead = 1'b1;
      else cursor = nx;
    end
    if (w.last)
      answers.push_back('{sae_pkg::ST_ANSWER, !dead && cursor < DEPTH && term[cursor]});
  endfunction

  function automatic void push_word(logic a, logic [4:0] s, logic f, logic l);
    word_t w;
    w.act = a; w.sym = s; w.first = f; w.last = l;
    pending.push_back(w);
    if (a == sae_pkg::ACT_APPEND && s < ALPHA && !l) text.push_back(s);
  endfunction

  // Queue a pattern taken from the text so far, optionally garbled
  function automatic void push_pattern(bit tail_only, bit garble, bit cont);
    int n, len, start;
    logic [4:0] s;
    n = text.size();
    if (n == 0) begin
      push_word(sae_pkg::ACT_QUERY, 5'($urandom_range(0, 31)), 1'b1, 1'b1);
      return;
    end
    len = $urandom_range(1, (n < 12) ? n : 12);
    start = tail_only ? n - len : $urandom_range(0, n - len);
    for (int i = 0; i < len; i++) begin
      s = text[start + i];
      if (garble && $urandom_range(0, 3) == 0) s = 5'($urandom_range(0, 31));
      push_word(sae_pkg::ACT_QUERY, s, (i == 0) && !cont, i == len - 1);
    end
  endfunction

  function automatic int idle_mode();
    return (accepted_words * 4) / (total_words + 1);
  endfunction

  // Drive words: take the next pending word after a handshake or an idle slot
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_word('{action, symbol, first, last});
        accepted_words++;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 &&
            !((idle_mode() == 1 && $urandom_range(0, 99) < 46) ||
              (idle_mode() == 3 && $urandom_range(0, 99) < 34))) begin
          word_t w;
          w = pending.pop_front();
          in_valid <= 1'b1;
          action <= w.act;
          symbol <= w.sym;
          first <= w.first;
          last <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the output; one long hold-off lets the block back up
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && accepted_words > total_words / 2) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      if ((idle_mode() == 2 && $urandom_range(0, 99) < 46) ||
          (idle_mode() == 3 && $urandom_range(0, 99) < 34))
        out_stall <= 1'b1;
      else
        out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_results++;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result status=%0d found=%0d", $time, status, found);
        fail_count++;
      end else begin
        answer_t e;
        e = answers.pop_front();
        if (status !== e.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, status);
          fail_count++;
        end
        if (found !== e.found) begin
          $display("%0t: found mismatch expected %0d actual %0d", $time, e.found, found);
          fail_count++;
        end
        if (e.found) hits++;
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int r;
    clear_automaton();
    // Directed: empty text, bad symbols, extremes, open-text queries
    push_word(sae_pkg::ACT_QUERY, 5'd0, 1'b1, 1'b1);
    push_word(sae_pkg::ACT_QUERY, 5'd31, 1'b1, 1'b1);
    push_word(sae_pkg::ACT_APPEND, 5'd26, 1'b0, 1'b0);
    push_word(sae_pkg::ACT_APPEND, 5'd31, 1'b1, 1'b1);
    push_word(sae_pkg::ACT_APPEND, 5'd0, 1'b0, 1'b0);
    push_word(sae_pkg::ACT_APPEND, 5'd25, 1'b1, 1'b0);
    push_word(sae_pkg::ACT_APPEND, 5'd0, 1'b0, 1'b0);
    push_word(sae_pkg::ACT_APPEND, 5'd0, 1'b0, 1'b0);
    push_word(sae_pkg::ACT_QUERY, 5'd0, 1'b1, 1'b0);
    push_word(sae_pkg::ACT_QUERY, 5'd0, 1'b0, 1'b1);
    push_word(sae_pkg::ACT_QUERY, 5'd25, 1'b0, 1'b1);
    push_word(sae_pkg::ACT_QUERY, 5'd30, 1'b1, 1'b0);
    push_word(sae_pkg::ACT_QUERY, 5'd0, 1'b0, 1'b1);
    // Random text build over a small alphabet, with queries mixed in
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        push_word(sae_pkg::ACT_APPEND, 5'($urandom_range(26, 31)), 1'b0,
                  1'($urandom_range(0, 1)));
      else if (r < 15)
        push_word(sae_pkg::ACT_APPEND, 5'($urandom_range(0, 25)), 1'b0, 1'b0);
      else if (r < 80)
        push_word(sae_pkg::ACT_APPEND, 5'($urandom_range(0, 2)),
                  1'($urandom_range(0, 1)), 1'b0);
      else push_pattern(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 1'b0);
    end
    // Close the text
    push_word(sae_pkg::ACT_APPEND, 5'd1, 1'b0, 1'b1);
    text.push_back(5'd1);
    // Queries on the closed text, plus appends after the end
    for (int i = 0; i < 90; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) push_pattern(1'b1, 1'b0, 1'b0);
      else if (r < 70) push_pattern(1'b0, 1'b0, 1'b0);
      else if (r < 80) push_pattern(1'($urandom_range(0, 1)), 1'b1, 1'b0);
      else if (r < 88) push_pattern(1'b1, 1'b0, 1'b1);
      else push_word(sae_pkg::ACT_APPEND, 5'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    total_words = pending.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !in_valid);
    wait (answers.size() == 0);
    repeat (2000) @(posedge clk);

    $display("Covered %0d appends and %0d query symbols; %0d results checked, %0d suffix hits.",
             n_appends, n_queries, seen_results, hits);
    $display("Text length %0d with %0d automaton states; one long output hold-off applied.",
             text_len, free_id);
    if (fail_count == 0 && answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/sae_pkg.sv
src/sae_datapath.sv
src/sae_ctrl.sv
src/suffix_automaton_engine.sv
src/sae_checker.sv
dv/testbench.sv
